@@ rtl/pkhfa_pkg.sv @@
// Shared types and constants for the plane key find-or-add table.
package pkhfa_pkg;

  localparam int SUM_W = 19;
  localparam int KEY_W = 56;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_FIND  = 2'd1,
    CMD_SPLIT = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_SRC,
    ST_SUM,
    ST_MUL,
    ST_QB,
    ST_MOD,
    ST_BKT,
    ST_WALK,
    ST_APP,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [31:0] height;
    logic [15:0] flat;
    logic [7:0]  light;
  } key_t;

endpackage

@@ rtl/pkhfa_in_if.sv @@
// Input channel: command word with plane key and split source.
interface pkhfa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] height;
  logic [15:0]        flat_id;
  logic [7:0]         light_level;
  logic [8:0]         source_plane;

  modport source (
    output valid, command, height, flat_id, light_level, source_plane,
    input  ready
  );
  modport sink (
    input  valid, command, height, flat_id, light_level, source_plane,
    output ready
  );
endinterface

@@ rtl/pkhfa_out_if.sv @@
// Output channel: result word with entry number and status flags.
interface pkhfa_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] plane_id;
  logic       created;
  logic       table_full;

  modport source (
    output valid, plane_id, created, table_full,
    input  ready
  );
  modport sink (
    input  valid, plane_id, created, table_full,
    output ready
  );
endinterface

@@ rtl/plane_key_hash_find_or_add_core.sv @@
// Find-or-add table of plane keys with per-bucket chains kept in RAM.
//
//   port     dir   word                                                    handshake
//   in_i     in    command, height, flat_id, light_level, source_plane     valid/ready
//   out_o    out   plane_id, created, table_full                           valid/ready
//   apb      in    sky_flat at address 0                                   psel/penable
//
// One word in flight. Find hashes the key, reads the bucket and compares chain entries
// one per cycle, appending when none matches. Split reads the source entry's key (or uses
// a zero key for a source beyond the table) and appends. Full split, reserved command:
// straight to the response. Clear sweeps the bucket RAM.
// After reset the bucket RAM is swept with in_i.ready low.
// The result sits in an output register; a new word is taken while it waits.
module plane_key_hash_find_or_add_core #(
  parameter int MAX_PLANES = 512,
  parameter int BUCKETS    = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pkhfa_in_if.sink    in_i,
  pkhfa_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW  = $clog2(MAX_PLANES);
  localparam int CW  = $clog2(MAX_PLANES + 1);
  localparam int BW  = $clog2(BUCKETS);
  localparam int SW  = pkhfa_pkg::SUM_W;
  localparam int KW  = pkhfa_pkg::KEY_W;
  localparam int BKW = 1 + 2 * IW;
  localparam logic [SW-1:0] RECIP = SW'((1 << SW) / BUCKETS);
  localparam logic [1:0] ADDR_SKY_FLAT = 2'd0;

  pkhfa_pkg::state_e state_q, state_d;
  pkhfa_pkg::key_t   key_q, key_d, key_rd;

  logic          split_q, split_d;
  logic [SW-1:0] sum_q, sum_d, quo_q, quo_d, qb_q, qb_d, rem;
  logic [2*SW-1:0] prod;
  logic [BW-1:0] bkt_q, bkt_d, bkt_hash, sweep_q, sweep_d;
  logic          head_vld_q, head_vld_d;
  logic [IW-1:0] head_q, head_d, tail_q, tail_d, cur_q, cur_d, new_idx;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] res_id_q, res_id_d;
  logic          res_created_q, res_created_d, res_full_q, res_full_d;
  logic          out_vld_q, out_vld_d;
  logic [8:0]    out_id_q, out_id_d;
  logic          out_created_q, out_created_d, out_full_q, out_full_d;
  logic [15:0]   sky_q;
  logic          in_fire, full;

  logic           key_we, next_we, bkt_we;
  logic [IW-1:0]  key_waddr, next_waddr, ent_raddr;
  logic [KW-1:0]  key_rdata;
  logic [IW-1:0]  next_wdata, next_rdata;
  logic [BW-1:0]  bkt_waddr, bkt_raddr;
  logic [BKW-1:0] bkt_wdata, bkt_rdata;

  pkhfa_ram #(.WIDTH(KW), .DEPTH(MAX_PLANES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_q),
    .raddr_i (ent_raddr),
    .rdata_o (key_rdata)
  );

  pkhfa_ram #(.WIDTH(IW), .DEPTH(MAX_PLANES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (next_rdata)
  );

  // bucket word: {head valid, head, tail}
  pkhfa_ram #(.WIDTH(BKW), .DEPTH(BUCKETS)) u_bkt_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_waddr),
    .wdata_i (bkt_wdata),
    .raddr_i (bkt_raddr),
    .rdata_o (bkt_rdata)
  );

  assign key_rd   = key_rdata;
  assign in_fire  = in_i.valid && in_i.ready;
  assign full     = (count_q == CW'(MAX_PLANES));
  assign new_idx  = IW'(count_q);
  assign prod     = (2 * SW)'(sum_q) * (2 * SW)'(RECIP);
  assign rem      = sum_q - qb_q;
  assign bkt_hash = (rem >= SW'(BUCKETS)) ? BW'(rem - SW'(BUCKETS)) : BW'(rem);

  assign in_i.ready       = (state_q == pkhfa_pkg::ST_IDLE);
  assign out_o.valid      = out_vld_q;
  assign out_o.plane_id   = out_id_q;
  assign out_o.created    = out_created_q;
  assign out_o.table_full = out_full_q;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SKY_FLAT) ? {16'd0, sky_q} : 32'd0;

  always_comb begin
    state_d       = state_q;
    split_d       = split_q;
    key_d         = key_q;
    sum_d         = sum_q;
    quo_d         = quo_q;
    qb_d          = qb_q;
    bkt_d         = bkt_q;
    head_vld_d    = head_vld_q;
    head_d        = head_q;
    tail_d        = tail_q;
    cur_d         = cur_q;
    count_d       = count_q;
    sweep_d       = sweep_q;
    res_id_d      = res_id_q;
    res_created_d = res_created_q;
    res_full_d    = res_full_q;
    out_vld_d     = out_vld_q && !out_o.ready;
    out_id_d      = out_id_q;
    out_created_d = out_created_q;
    out_full_d    = out_full_q;
    key_we        = 1'b0;
    key_waddr     = new_idx;
    next_we       = 1'b0;
    next_waddr    = tail_q;
    next_wdata    = new_idx;
    bkt_we        = 1'b0;
    bkt_waddr     = bkt_q;
    bkt_wdata     = '0;
    bkt_raddr     = bkt_q;
    ent_raddr     = cur_q;

    unique case (state_q)
      pkhfa_pkg::ST_INIT, pkhfa_pkg::ST_CLR: begin
        bkt_we    = 1'b1;
        bkt_waddr = sweep_q;
        if (sweep_q == BW'(BUCKETS - 1)) begin
          sweep_d = '0;
          state_d = (state_q == pkhfa_pkg::ST_INIT) ? pkhfa_pkg::ST_IDLE
                                                    : pkhfa_pkg::ST_RESP;
        end else begin
          sweep_d = sweep_q + BW'(1);
        end
      end
      pkhfa_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_id_d      = '0;
          res_created_d = 1'b0;
          res_full_d    = 1'b0;
          split_d       = (in_i.command == pkhfa_pkg::CMD_SPLIT);
          unique case (in_i.command)
            pkhfa_pkg::CMD_CLEAR: begin
              count_d = '0;
              sweep_d = '0;
              state_d = pkhfa_pkg::ST_CLR;
            end
            pkhfa_pkg::CMD_FIND: begin
              key_d.height = in_i.height;
              key_d.flat   = in_i.flat_id;
              key_d.light  = in_i.light_level;
              if (in_i.flat_id == sky_q) begin
                key_d.height = '0;
                key_d.light  = '0;
              end
              state_d = pkhfa_pkg::ST_SUM;
            end
            pkhfa_pkg::CMD_SPLIT: begin
              key_d = '0;
              if (full) begin
                res_full_d = 1'b1;
                state_d    = pkhfa_pkg::ST_RESP;
              end else if (32'(in_i.source_plane) < 32'(MAX_PLANES)) begin
                ent_raddr = IW'(in_i.source_plane);
                state_d   = pkhfa_pkg::ST_SRC;
              end else begin
                state_d = pkhfa_pkg::ST_SUM;
              end
            end
            default: begin
              state_d = pkhfa_pkg::ST_RESP;
            end
          endcase
        end
      end
      pkhfa_pkg::ST_SRC: begin
        key_d   = key_rd;
        state_d = pkhfa_pkg::ST_SUM;
      end
      pkhfa_pkg::ST_SUM: begin
        sum_d   = SW'({key_q.flat, 1'b0}) + SW'(key_q.flat) + SW'(key_q.light)
                + SW'(key_q.height[31:16]);
        state_d = pkhfa_pkg::ST_MUL;
      end
      pkhfa_pkg::ST_MUL: begin
        quo_d   = prod[2*SW-1:SW];
        state_d = pkhfa_pkg::ST_QB;
      end
      pkhfa_pkg::ST_QB: begin
        qb_d    = quo_q * SW'(BUCKETS);
        state_d = pkhfa_pkg::ST_MOD;
      end
      pkhfa_pkg::ST_MOD: begin
        bkt_d     = bkt_hash;
        bkt_raddr = bkt_hash;
        state_d   = pkhfa_pkg::ST_BKT;
      end
      pkhfa_pkg::ST_BKT: begin
        head_vld_d = bkt_rdata[BKW-1];
        head_d     = bkt_rdata[2*IW-1:IW];
        tail_d     = bkt_rdata[IW-1:0];
        if (split_q) begin
          state_d = pkhfa_pkg::ST_APP;
        end else if (!bkt_rdata[BKW-1]) begin
          if (full) begin
            res_full_d = 1'b1;
            state_d    = pkhfa_pkg::ST_RESP;
          end else begin
            state_d = pkhfa_pkg::ST_APP;
          end
        end else begin
          cur_d     = bkt_rdata[2*IW-1:IW];
          ent_raddr = bkt_rdata[2*IW-1:IW];
          state_d   = pkhfa_pkg::ST_WALK;
        end
      end
      pkhfa_pkg::ST_WALK: begin
        if (key_rd == key_q) begin
          res_id_d = cur_q;
          state_d  = pkhfa_pkg::ST_RESP;
        end else if (cur_q == tail_q) begin
          if (full) begin
            res_full_d = 1'b1;
            state_d    = pkhfa_pkg::ST_RESP;
          end else begin
            state_d = pkhfa_pkg::ST_APP;
          end
        end else begin
          cur_d     = next_rdata;
          ent_raddr = next_rdata;
        end
      end
      pkhfa_pkg::ST_APP: begin
        key_we        = 1'b1;
        bkt_we        = 1'b1;
        bkt_wdata     = {1'b1, (head_vld_q ? head_q : new_idx), new_idx};
        next_we       = head_vld_q;
        count_d       = count_q + CW'(1);
        res_id_d      = new_idx;
        res_created_d = 1'b1;
        state_d       = pkhfa_pkg::ST_RESP;
      end
      pkhfa_pkg::ST_RESP: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d     = 1'b1;
          out_id_d      = 9'(res_id_q);
          out_created_d = res_created_q;
          out_full_d    = res_full_q;
          state_d       = pkhfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pkhfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pkhfa_pkg::ST_INIT;
      count_q   <= '0;
      sweep_q   <= '0;
      out_vld_q <= 1'b0;
      sky_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      sweep_q   <= sweep_d;
      out_vld_q <= out_vld_d;
      if (psel && penable && pwrite && paddr == ADDR_SKY_FLAT) begin
        sky_q <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    split_q       <= split_d;
    key_q         <= key_d;
    sum_q         <= sum_d;
    quo_q         <= quo_d;
    qb_q          <= qb_d;
    bkt_q         <= bkt_d;
    head_vld_q    <= head_vld_d;
    head_q        <= head_d;
    tail_q        <= tail_d;
    cur_q         <= cur_d;
    res_id_q      <= res_id_d;
    res_created_q <= res_created_d;
    res_full_q    <= res_full_d;
    out_id_q      <= out_id_d;
    out_created_q <= out_created_d;
    out_full_q    <= out_full_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_PLANES))
    else $error("entry count beyond table size");

  a_out_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_created_q && out_full_q))
    else $error("result both created and full");

  a_app_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pkhfa_pkg::ST_APP |=> count_q == CW'($past(count_q) + CW'(1)))
    else $error("append did not bump entry count");

  a_walk_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pkhfa_pkg::ST_WALK |-> head_vld_q && !split_q)
    else $error("chain walk on empty bucket or split");

endmodule

@@ rtl/pkhfa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pkhfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
